FILE: hdl/mbm_pkg.sv
package mbm_pkg;

	localparam logic [7:0] PRG_COUNT_RESET = 8'd32;
	localparam int CHR_W = 9;
	localparam int CHR_HALF_W = 4 * CHR_W;
	localparam int PRG_W = 6;

	// configuration register indexes
	localparam logic [7:0] CFG_PRG_COUNT   = 8'd0;
	localparam logic [7:0] CFG_FOUR_SCREEN = 8'd1;

	// write decode
	localparam logic [15:0] ADDR_MASK       = 16'hE001;
	localparam logic [15:0] ADDR_LOW_LIMIT  = 16'h6000;
	localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRROR      = 16'hA000;
	localparam logic [15:0] REG_SRAM_CTRL   = 16'hA001;
	localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;

	// bank data targets selected by bank_command[2:0]
	localparam logic [2:0] SEL_CHR_2K_0 = 3'd0;
	localparam logic [2:0] SEL_CHR_2K_1 = 3'd1;
	localparam logic [2:0] SEL_CHR_1K_0 = 3'd2;
	localparam logic [2:0] SEL_CHR_1K_1 = 3'd3;
	localparam logic [2:0] SEL_CHR_1K_2 = 3'd4;
	localparam logic [2:0] SEL_CHR_1K_3 = 3'd5;
	localparam logic [2:0] SEL_PRG_0    = 3'd6;
	localparam logic [2:0] SEL_PRG_1    = 3'd7;

	localparam logic [1:0] MIRR_VERTICAL   = 2'd0;
	localparam logic [1:0] MIRR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIRR_FOUR       = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] address;
		logic [7:0]  value;
		logic        in_vblank;
	} item_t;

	typedef struct packed {
		logic [7:0]      bank_command;
		logic [7:0]      outer_block;
		logic [7:0]      sram_control;
		logic [1:0][7:0] prg_regs;
		logic [5:0][7:0] chr_regs;
		logic            irq_enabled;
		logic [7:0]      irq_counter;
		logic [7:0]      irq_reload;
		logic            mirror_horizontal;
	} map_state_t;

	typedef struct packed {
		logic [3:0][PRG_W-1:0] prg;
		logic [CHR_HALF_W-1:0] chr_lower;
		logic [CHR_HALF_W-1:0] chr_upper;
		logic [1:0]            mirroring;
	} result_t;

endpackage

FILE: hdl/mbm_regs.sv
module mbm_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  mbm_pkg::item_t      item,
	input  logic                four_screen,
	output mbm_pkg::map_state_t state_nxt,
	output logic                irq_nxt
);
	import mbm_pkg::*;

	map_state_t state_q;

	always_comb begin
		state_nxt = state_q;
		irq_nxt = 1'b0;
		if (item.cmd) begin
			if (!item.in_vblank && state_q.irq_enabled) begin
				if (state_q.irq_counter == 8'd0) begin
					state_nxt.irq_counter = state_q.irq_reload;
					irq_nxt = 1'b1;
				end else begin
					state_nxt.irq_counter = state_q.irq_counter - 8'd1;
				end
			end
		end else if (item.address >= ADDR_LOW_LIMIT) begin
			if (!item.address[15]) begin
				if (state_q.sram_control[7])
					state_nxt.outer_block = item.value;
			end else begin
				unique case (item.address & ADDR_MASK)
					REG_BANK_SELECT: state_nxt.bank_command = item.value;
					REG_BANK_DATA: begin
						unique case (state_q.bank_command[2:0])
							SEL_CHR_2K_0: state_nxt.chr_regs[0] = {item.value[7:1], 1'b0};
							SEL_CHR_2K_1: state_nxt.chr_regs[1] = {item.value[7:1], 1'b0};
							SEL_CHR_1K_0: state_nxt.chr_regs[2] = item.value;
							SEL_CHR_1K_1: state_nxt.chr_regs[3] = item.value;
							SEL_CHR_1K_2: state_nxt.chr_regs[4] = item.value;
							SEL_CHR_1K_3: state_nxt.chr_regs[5] = item.value;
							SEL_PRG_0:    state_nxt.prg_regs[0] = item.value;
							SEL_PRG_1:    state_nxt.prg_regs[1] = item.value;
							default:      state_nxt.prg_regs[1] = item.value;
						endcase
					end
					REG_MIRROR: begin
						if (!four_screen)
							state_nxt.mirror_horizontal = item.value[0];
					end
					REG_SRAM_CTRL:   state_nxt.sram_control = item.value;
					REG_IRQ_COUNT:   state_nxt.irq_counter = item.value;
					REG_IRQ_RELOAD:  state_nxt.irq_reload = item.value;
					REG_IRQ_DISABLE: state_nxt.irq_enabled = 1'b0;
					default:         state_nxt.irq_enabled = 1'b1;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.bank_command <= '0;
			state_q.outer_block <= '0;
			state_q.sram_control <= '0;
			state_q.prg_regs[0] <= 8'd0;
			state_q.prg_regs[1] <= 8'd1;
			state_q.chr_regs[0] <= 8'd0;
			state_q.chr_regs[1] <= 8'd2;
			state_q.chr_regs[2] <= 8'd4;
			state_q.chr_regs[3] <= 8'd5;
			state_q.chr_regs[4] <= 8'd6;
			state_q.chr_regs[5] <= 8'd7;
			state_q.irq_enabled <= 1'b0;
			state_q.irq_counter <= '0;
			state_q.irq_reload <= '0;
			state_q.mirror_horizontal <= 1'b0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: hdl/mbm_decode.sv
module mbm_decode (
	input  mbm_pkg::map_state_t state,
	input  logic [7:0]          prg_count,
	input  logic                four_screen,
	output mbm_pkg::result_t    result
);
	import mbm_pkg::*;

	logic [3:0]       last_bank;
	logic [1:0]       outer_hi;
	logic [PRG_W-1:0] v0;
	logic [PRG_W-1:0] v1;
	logic [PRG_W-1:0] fixed;
	logic [PRG_W-1:0] base;
	logic [5:0][CHR_W-1:0] c;
	logic [CHR_HALF_W-1:0] pairs;
	logic [CHR_HALF_W-1:0] singles;

	always_comb begin
		// last 8KB bank is 2*count-1, modulo 16
		last_bank = {prg_count[2:0], 1'b0} - 4'd1;
		outer_hi = state.outer_block[7:6];
		v0 = {outer_hi, state.prg_regs[0][3:0]};
		v1 = {outer_hi, state.prg_regs[1][3:0]};
		fixed = {outer_hi, last_bank[3:1], 1'b0};
		base = {1'b0, state.outer_block[6:4], 2'b00};

		if (state.outer_block[0]) begin
			result.prg[0] = state.bank_command[6] ? fixed : v0;
			result.prg[2] = state.bank_command[6] ? v0 : fixed;
			result.prg[1] = v1;
			result.prg[3] = {outer_hi, last_bank};
		end else begin
			result.prg[0] = base;
			result.prg[1] = base | PRG_W'(1);
			result.prg[2] = base | PRG_W'(2);
			result.prg[3] = base | PRG_W'(3);
		end

		for (int i = 0; i < 6; i++)
			c[i] = {1'b0, state.chr_regs[i]} | {outer_hi, 7'd0};
		pairs = {CHR_W'(c[1] + CHR_W'(1)), c[1], CHR_W'(c[0] + CHR_W'(1)), c[0]};
		singles = {c[5], c[4], c[3], c[2]};
		result.chr_lower = state.bank_command[7] ? singles : pairs;
		result.chr_upper = state.bank_command[7] ? pairs : singles;

		if (four_screen)
			result.mirroring = MIRR_FOUR;
		else if (state.mirror_horizontal)
			result.mirroring = MIRR_HORIZONTAL;
		else
			result.mirroring = MIRR_VERTICAL;
	end

endmodule

FILE: hdl/multicart_bank_mapper_irq_top.sv
// Multicart bank mapper with scanline IRQ counter.
//
// Input channel (in_valid / in_stall): one transaction is either a CPU write
// (cmd = 0, address, value) or a scanline tick (cmd = 1, in_vblank).
// Output channel (out_valid / out_stall): exactly one result per input
// transaction, in order: the four 8KB PRG banks, the eight 1KB CHR banks
// (two packed halves of 9-bit slots), the mirroring mode and an IRQ pulse.
// The result reflects the mapper state after that transaction.
//
// One transaction per cycle is sustained while out_stall is low. The input
// register feeds the register update and bank decode logic, which load the
// output register.
// While out_stall holds a waiting result, one more transaction is taken into
// the input register, then in_stall rises until the output drains.
//
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 is the 16KB PRG bank count, index 1 the four-screen flag; other
// indexes are ignored. Reset empties both stages and restores all mapper
// registers and configuration to their power-on values.
module multicart_bank_mapper_irq_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [15:0]                    address,
	input  logic [7:0]                     value,
	input  logic                           in_vblank,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mbm_pkg::PRG_W-1:0]      prg_bank_8000,
	output logic [mbm_pkg::PRG_W-1:0]      prg_bank_a000,
	output logic [mbm_pkg::PRG_W-1:0]      prg_bank_c000,
	output logic [mbm_pkg::PRG_W-1:0]      prg_bank_e000,
	output logic [mbm_pkg::CHR_HALF_W-1:0] chr_banks_lower,
	output logic [mbm_pkg::CHR_HALF_W-1:0] chr_banks_upper,
	output logic [1:0]                     mirroring,
	output logic                           irq_request,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_index,
	input  logic [7:0]                     cfg_data
);
	import mbm_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       irq_s2;
	logic [7:0] prg_count_q;
	logic       four_screen_q;

	logic       advance;
	logic       fire;
	map_state_t state_nxt;
	logic       irq_nxt;
	result_t    res_nxt;

	assign advance = !valid_s2 || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RESET;
			four_screen_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PRG_COUNT)
				prg_count_q <= cfg_data;
			else if (cfg_index == CFG_FOUR_SCREEN)
				four_screen_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{cmd: cmd, address: address, value: value, in_vblank: in_vblank};
		if (fire) begin
			res_s2 <= res_nxt;
			irq_s2 <= irq_nxt;
		end
	end

	mbm_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.four_screen(four_screen_q),
		.state_nxt  (state_nxt),
		.irq_nxt    (irq_nxt)
	);

	mbm_decode u_decode (
		.state      (state_nxt),
		.prg_count  (prg_count_q),
		.four_screen(four_screen_q),
		.result     (res_nxt)
	);

	assign out_valid = valid_s2;
	assign prg_bank_8000 = res_s2.prg[0];
	assign prg_bank_a000 = res_s2.prg[1];
	assign prg_bank_c000 = res_s2.prg[2];
	assign prg_bank_e000 = res_s2.prg[3];
	assign chr_banks_lower = res_s2.chr_lower;
	assign chr_banks_upper = res_s2.chr_upper;
	assign mirroring = res_s2.mirroring;
	assign irq_request = irq_s2;

endmodule

FILE: hdl/mbm_checker.sv
module mbm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mbm_pkg::PRG_W-1:0]      prg_bank_8000,
	input logic [mbm_pkg::CHR_HALF_W-1:0] chr_banks_lower,
	input logic [1:0]                     mirroring,
	input logic                           cfg_ready
);
	import mbm_pkg::*;

	// a held result stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prg_bank_8000)
			&& $stable(chr_banks_lower))
		else $error("result changed while stalled");

	// with the output empty nothing can back up into the input register
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_mirroring_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mirroring != 2'd3)
		else $error("bad mirroring code");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

	// an accepted transaction with a free output passes the input register and shows up from the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> ##1 out_valid)
		else $error("result missing after accept");

endmodule

bind multicart_bank_mapper_irq_top mbm_checker u_mbm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.prg_bank_8000  (prg_bank_8000),
	.chr_banks_lower(chr_banks_lower),
	.mirroring      (mirroring),
	.cfg_ready      (cfg_ready)
);

FILE: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mbm_pkg::*;

	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam logic [15:0] REG_IRQ_ENABLE = REG_IRQ_DISABLE | 16'h0001;
	localparam logic [15:0] OUTER_REG_LAST = REG_BANK_SELECT - 16'h0001;

	typedef struct packed {
		logic [PRG_W-1:0]      prg_8000;
		logic [PRG_W-1:0]      prg_a000;
		logic [PRG_W-1:0]      prg_c000;
		logic [PRG_W-1:0]      prg_e000;
		logic [CHR_HALF_W-1:0] chr_lo;
		logic [CHR_HALF_W-1:0] chr_hi;
		logic [1:0]            mirr;
		logic                  irq;
	} mapping_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [15:0] address;
	logic [7:0] value;
	logic in_vblank;
	logic out_valid;
	logic out_stall;
	logic [PRG_W-1:0] prg_bank_8000;
	logic [PRG_W-1:0] prg_bank_a000;
	logic [PRG_W-1:0] prg_bank_c000;
	logic [PRG_W-1:0] prg_bank_e000;
	logic [CHR_HALF_W-1:0] chr_banks_lower;
	logic [CHR_HALF_W-1:0] chr_banks_upper;
	logic [1:0] mirroring;
	logic irq_request;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_index;
	logic [7:0] cfg_data;

	// mapper shadow state
	logic [7:0] bank_cmd, outer_sel, sram_ctl, irq_count, irq_reload;
	logic [1:0][7:0] prg_reg;
	logic [5:0][7:0] chr_reg;
	logic irq_on, mirror_h;
	logic [7:0] bank_count;
	logic four_screen;

	mapping_t mappings_due[$];
	int mismatches = 0;
	int work_items = 0;
	int cycle_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_pending = 1'b0;

	multicart_bank_mapper_irq_top u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic mapping_t apply_item(input logic c, input logic [15:0] a,
			input logic [7:0] v, input logic vb);
		mapping_t m;
		logic [3:0] last;
		logic [PRG_W-1:0] fixed_bank, swap_bank;
		logic [8:0] cb;
		logic [5:0][8:0] chr;
		logic [CHR_HALF_W-1:0] pairs, singles;
		m.irq = 1'b0;
		if (c == CMD_TICK) begin
			if (!vb && irq_on) begin
				if (irq_count == 8'd0) begin
					irq_count = irq_reload;
					m.irq = 1'b1;
				end else begin
					irq_count = irq_count - 8'd1;
				end
			end
		end else if (a >= ADDR_LOW_LIMIT) begin
			if (a < REG_BANK_SELECT) begin
				if (sram_ctl[7])
					outer_sel = v;
			end else begin
				case (a & ADDR_MASK)
				REG_BANK_SELECT: bank_cmd = v;
				REG_BANK_DATA: begin
					case (bank_cmd[2:0])
					SEL_CHR_2K_0: chr_reg[0] = v & 8'hFE;
					SEL_CHR_2K_1: chr_reg[1] = v & 8'hFE;
					SEL_CHR_1K_0: chr_reg[2] = v;
					SEL_CHR_1K_1: chr_reg[3] = v;
					SEL_CHR_1K_2: chr_reg[4] = v;
					SEL_CHR_1K_3: chr_reg[5] = v;
					SEL_PRG_0:    prg_reg[0] = v;
					default:      prg_reg[1] = v;
					endcase
				end
				REG_MIRROR: begin
					if (!four_screen)
						mirror_h = v[0];
				end
				REG_SRAM_CTRL:   sram_ctl = v;
				REG_IRQ_COUNT:   irq_count = v;
				REG_IRQ_RELOAD:  irq_reload = v;
				REG_IRQ_DISABLE: irq_on = 1'b0;
				default:         irq_on = 1'b1;
				endcase
			end
		end

		if (outer_sel[0]) begin
			// banked mode; last bank wraps within 16
			last = {bank_count[2:0], 1'b0} - 4'd1;
			fixed_bank = {outer_sel[7:6], last[3:1], 1'b0};
			swap_bank = {outer_sel[7:6], prg_reg[0][3:0]};
			m.prg_8000 = bank_cmd[6] ? fixed_bank : swap_bank;
			m.prg_c000 = bank_cmd[6] ? swap_bank : fixed_bank;
			m.prg_a000 = {outer_sel[7:6], prg_reg[1][3:0]};
			m.prg_e000 = {outer_sel[7:6], last};
		end else begin
			m.prg_8000 = {1'b0, outer_sel[6:4], 2'd0};
			m.prg_a000 = {1'b0, outer_sel[6:4], 2'd1};
			m.prg_c000 = {1'b0, outer_sel[6:4], 2'd2};
			m.prg_e000 = {1'b0, outer_sel[6:4], 2'd3};
		end

		cb = {outer_sel[7:6], 7'd0};
		for (int i = 0; i < 6; i++)
			chr[i] = {1'b0, chr_reg[i]} | cb;
		pairs = {chr[1] + 9'd1, chr[1], chr[0] + 9'd1, chr[0]};
		singles = {chr[5], chr[4], chr[3], chr[2]};
		m.chr_lo = bank_cmd[7] ? singles : pairs;
		m.chr_hi = bank_cmd[7] ? pairs : singles;
		m.mirr = four_screen ? MIRR_FOUR : (mirror_h ? MIRR_HORIZONTAL : MIRR_VERTICAL);
		return m;
	endfunction

	function automatic logic [15:0] reg_addr(input logic [15:0] code);
		logic [15:0] r;
		r = 16'($urandom);
		return code | (r & ~ADDR_MASK);
	endfunction

	// valid stays up after a transaction; it drops only before a gap or a pause
	task automatic send_item(input logic c, input logic [15:0] a, input logic [7:0] v,
			input logic vb);
		int gap;
		gap = tx_idle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		address <= a;
		value <= v;
		in_vblank <= vb;
		do @(posedge clk); while (in_stall);
		mappings_due.push_back(apply_item(c, a, v, vb));
		if (c == CMD_TICK || a >= ADDR_LOW_LIMIT)
			work_items++;
	endtask

	task automatic send_write(input logic [15:0] a, input logic [7:0] v);
		send_item(CMD_WRITE, a, v, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_tick(input logic vb);
		logic [15:0] a;
		logic [7:0] v;
		a = 16'($urandom);
		v = 8'($urandom);
		send_item(CMD_TICK, a, v, vb);
	endtask

	task automatic send_noise();
		logic [15:0] a;
		logic [7:0] v;
		a = 16'($urandom);
		v = 8'($urandom);
		send_item(1'($urandom_range(0, 1)), a, v, 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (mappings_due.size() != 0)
			@(posedge clk);
	endtask

	// cfg_valid is left high between back-to-back writes
	task automatic write_setting(input logic [7:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_PRG_COUNT:   bank_count = data;
		CFG_FOUR_SCREEN: four_screen = data[0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [7:0] count, input logic four);
		write_setting(CFG_PRG_COUNT, count);
		write_setting(CFG_FOUR_SCREEN, {7'd0, four});
		// unmapped index must be a no-op
		write_setting(8'($urandom_range(CFG_FOUR_SCREEN + 1, 255)), 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_ignored_writes();
		send_item(CMD_TICK, 16'hFFFF, 8'hFF, 1'b1);
		send_write(16'h0000, 8'h00);
		send_write(ADDR_LOW_LIMIT - 16'h0001, 8'hFF);
		// outer register still locked
		send_write(OUTER_REG_LAST, 8'hFF);
	endtask

	task automatic test_bank_modes();
		send_write(REG_SRAM_CTRL, 8'h80);
		send_write(OUTER_REG_LAST, 8'hC1);
		send_write(REG_BANK_SELECT, 8'h46);
		send_write(REG_BANK_DATA, 8'hFF);
		send_write(REG_BANK_SELECT, 8'hC0);
		send_write(REG_BANK_DATA, 8'hFF);
		send_write(REG_MIRROR, 8'h01);
		send_write(ADDR_LOW_LIMIT, 8'h70);
	endtask

	task automatic test_irq_counter();
		send_write(REG_IRQ_COUNT, 8'h01);
		send_write(REG_IRQ_RELOAD, 8'hFF);
		send_write(REG_IRQ_ENABLE, 8'h00);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_write(REG_IRQ_DISABLE, 8'hFF);
		send_tick(1'b0);
	endtask

	task automatic test_settings();
		wait_all_results();
		apply_settings(8'd0, 1'b1);
		send_write(REG_MIRROR, 8'h00);
		send_write(ADDR_LOW_LIMIT, 8'h01);
		wait_all_results();
		apply_settings(8'd255, 1'b0);
		send_tick(1'b0);
	endtask

	task automatic test_output_backpressure();
		hold_pending = 1'b1;
		tx_idle = 1'b0;
		repeat (24) send_noise();
		wait_all_results();
		tx_idle = 1'b1;
	endtask

	task automatic traffic_phase(input logic [7:0] count, input logic four, input int target);
		int start;
		int n;
		logic [7:0] v;
		apply_settings(count, four);
		start = work_items;
		while (work_items - start < target) begin
			if ($urandom_range(0, 15) == 0) begin
				tx_idle = 1'($urandom_range(0, 1));
				rx_idle = 1'($urandom_range(0, 1));
			end
			case ($urandom_range(0, 10))
			0, 1: begin
				send_write(reg_addr(REG_BANK_SELECT), 8'($urandom));
				send_write(reg_addr(REG_BANK_DATA), 8'($urandom));
			end
			2: begin
				v = 8'($urandom);
				v[7] = ($urandom_range(0, 3) != 0);
				send_write(reg_addr(REG_SRAM_CTRL), v);
				send_write(16'($urandom_range(ADDR_LOW_LIMIT, OUTER_REG_LAST)),
					8'($urandom));
			end
			3, 4: begin
				send_write(reg_addr(REG_IRQ_COUNT), 8'($urandom_range(0, 5)));
				send_write(reg_addr(REG_IRQ_RELOAD), 8'($urandom_range(0, 5)));
				send_write(reg_addr(REG_IRQ_ENABLE), 8'($urandom));
				n = $urandom_range(3, 12);
				repeat (n) send_tick($urandom_range(0, 7) == 0);
			end
			5: send_write(reg_addr(REG_MIRROR), 8'($urandom));
			6: begin
				n = $urandom_range(1, 4);
				repeat (n) send_tick(1'($urandom_range(0, 1)));
			end
			7: send_noise();
			8: send_write(16'($urandom_range(0, ADDR_LOW_LIMIT - 1)), 8'($urandom));
			9: send_write(reg_addr($urandom_range(0, 1) ? REG_IRQ_COUNT : REG_IRQ_RELOAD),
					8'($urandom));
			default: send_write(reg_addr(REG_IRQ_DISABLE), 8'($urandom));
			endcase
		end
		wait_all_results();
	endtask

	task automatic test_random_traffic();
		traffic_phase(8'($urandom_range(1, 255)), 1'b0, 240);
		traffic_phase(8'd1, 1'b1, 230);
		traffic_phase(8'd255, 1'b0, 230);
		traffic_phase(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), 240);
	endtask

	// result side: random stall after each transaction, long hold on request
	initial begin : result_sink
		int pause;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_valid && !out_stall) begin
				pause = rx_idle ? $urandom_range(0, 7) : 0;
				if (pause > 0) begin
					out_stall <= 1'b1;
					repeat (pause) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string field, input logic [CHR_HALF_W-1:0] want,
			input logic [CHR_HALF_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		mapping_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (mappings_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual prg %h %h %h %h",
					$time, prg_bank_8000, prg_bank_a000, prg_bank_c000, prg_bank_e000);
				mismatches++;
			end else begin
				want = mappings_due.pop_front();
				check_field("prg_bank_8000", CHR_HALF_W'(want.prg_8000),
					CHR_HALF_W'(prg_bank_8000));
				check_field("prg_bank_a000", CHR_HALF_W'(want.prg_a000),
					CHR_HALF_W'(prg_bank_a000));
				check_field("prg_bank_c000", CHR_HALF_W'(want.prg_c000),
					CHR_HALF_W'(prg_bank_c000));
				check_field("prg_bank_e000", CHR_HALF_W'(want.prg_e000),
					CHR_HALF_W'(prg_bank_e000));
				check_field("chr_banks_lower", want.chr_lo, chr_banks_lower);
				check_field("chr_banks_upper", want.chr_hi, chr_banks_upper);
				check_field("mirroring", CHR_HALF_W'(want.mirr), CHR_HALF_W'(mirroring));
				check_field("irq_request", CHR_HALF_W'(want.irq), CHR_HALF_W'(irq_request));
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_WRITE;
		address <= 16'h0000;
		value <= 8'h00;
		in_vblank <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_PRG_COUNT;
		cfg_data <= 8'h00;
		bank_cmd = 8'h00;
		outer_sel = 8'h00;
		sram_ctl = 8'h00;
		prg_reg = {8'd1, 8'd0};
		chr_reg = {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
		irq_on = 1'b0;
		irq_count = 8'h00;
		irq_reload = 8'h00;
		mirror_h = 1'b0;
		bank_count = PRG_COUNT_RESET;
		four_screen = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_ignored_writes();
		test_bank_modes();
		test_irq_counter();
		test_settings();
		test_output_backpressure();
		test_random_traffic();

		// catch any stray result after the queue has drained
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
